// ----- sv/pkbd_pkg.sv -----
// types and constants shared by the key block entry decoder
`timescale 1ns / 1ps

package pkbd_pkg;

    localparam int unsigned REGION_W = 17;
    localparam int unsigned LEN_W    = 32;
    localparam logic [REGION_W-1:0] OFFSET_SAT = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_REGION,
        ST_CHK_SHARED,
        ST_CHK_KEY,
        ST_BURST_RD,
        ST_BURST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_SHARED    = 3'd0,
        PH_SUFFIX    = 3'd1,
        PH_VALUE     = 3'd2,
        PH_KEY_BYTES = 3'd3,
        PH_VAL_BYTES = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_VARINT  = 2'd0,
        ERR_SHARED  = 2'd1,
        ERR_REGION  = 2'd2,
        ERR_KEY_LEN = 2'd3
    } err_t;

    typedef struct packed {
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
        logic [LEN_W-1:0] c;
    } cmp_req_t;

endpackage

// ----- sv/pkbd_ram.sv -----
// generic single-write ram with registered read
`timescale 1ns / 1ps

module pkbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/pkbd_cmp.sv -----
// shared length unit: flags a + b greater than c
`timescale 1ns / 1ps

module pkbd_cmp (
    input  pkbd_pkg::cmp_req_t req,
    output logic               gt
);

    import pkbd_pkg::*;

    logic [LEN_W:0] sum;

    assign sum = {1'b0, req.a} + {1'b0, req.b};
    assign gt  = sum > {1'b0, req.c};

endmodule

// ----- sv/prefix_key_block_entry_decoder.sv -----
// Decodes the entry region of a prefix-compressed key/value block, one byte per
// input word. Each entry is three varints (shared length, suffix length, value
// length), then suffix bytes and value bytes; the decoder returns the rebuilt
// key (shared prefix from its key buffer, then suffix) and the value, one byte
// per output word, with entry_end on the final word of each entry and run_last
// on the last word caused by one input byte. Varint, key and value bytes pass
// without wait states while the output register is free; a waiting output word
// holds the input off. After the byte completing the value-length varint the
// input is held while one shared add/compare unit checks region, shared length
// and key length in turn (an error ends the checks early), then while each
// shared prefix byte is read from the key buffer and then output. Errors give
// one error word and halt decoding until block_start. The key buffer needs no
// clearing after reset.
`timescale 1ns / 1ps

module prefix_key_block_entry_decoder #(
    parameter int unsigned KEY_MAX   = 64,
    parameter int unsigned BLOCK_MAX = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data,    // region_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // block_byte
    input  logic [0:0]  s_tuser,     // block_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // data_byte
    output logic [4:0]  m_tuser,     // item_kind[1:0], entry_end[2], error_code[4:3]
    output logic        m_tlast      // run_last
);

    import pkbd_pkg::*;

    localparam int unsigned KLW = $clog2(KEY_MAX + 1);
    localparam int unsigned AW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int unsigned CAP = (BLOCK_MAX > 131071) ? 131071 : BLOCK_MAX;
    localparam logic [REGION_W-1:0] LIMIT_CAP = REGION_W'(CAP);

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next, phase_eff;
    logic [REGION_W-1:0] region_reg, region_next;
    logic [REGION_W-1:0] offset_reg, offset_next, offset_eff, offset_inc;
    logic [KLW-1:0]     key_len_reg, key_len_next, key_len_eff;
    logic [KLW-1:0]     rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0]   acc_reg, acc_next, acc_eff, acc_new, acc_part;
    logic [2:0]         cnt_reg, cnt_next, cnt_eff, cnt_clamp;
    logic [LEN_W-1:0]   shared_reg, shared_next, shared_eff;
    logic [LEN_W-1:0]   suffix_reg, suffix_next, suffix_eff, suffix_dec;
    logic [LEN_W-1:0]   value_reg, value_next, value_eff, value_dec;
    logic               halted_reg, halted_next, halted_eff;

    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg, ld_kind;
    err_t               m_code_reg, ld_code;
    logic [7:0]         m_byte_reg, ld_byte;
    logic               m_end_reg, ld_end;
    logic               m_last_reg, ld_last;
    logic               out_ld, out_free;

    logic [REGION_W-1:0] limit;
    logic               s_accept, entry_done;
    cmp_req_t           cmp_req;
    logic               cmp_gt;
    logic               ram_we, ram_re;
    logic [7:0]         ram_rdata;

    pkbd_cmp u_cmp (
        .req (cmp_req),
        .gt  (cmp_gt)
    );

    pkbd_ram #(
        .WIDTH (8),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (key_len_eff[AW-1:0]),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign cfg_ready  = 1'b1;
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign limit      = (region_reg > LIMIT_CAP) ? LIMIT_CAP : region_reg;
    assign entry_done = (suffix_reg == '0) && (value_reg == '0);

    assign region_next = (cfg_valid && cfg_ready) ? cfg_data : region_reg;

    // state as seen after an optional block start
    always_comb begin
        if (s_tuser[0]) begin
            phase_eff   = PH_SHARED;
            offset_eff  = '0;
            key_len_eff = '0;
            acc_eff     = '0;
            cnt_eff     = '0;
            shared_eff  = '0;
            suffix_eff  = '0;
            value_eff   = '0;
            halted_eff  = 1'b0;
        end else begin
            phase_eff   = phase_reg;
            offset_eff  = offset_reg;
            key_len_eff = key_len_reg;
            acc_eff     = acc_reg;
            cnt_eff     = cnt_reg;
            shared_eff  = shared_reg;
            suffix_eff  = suffix_reg;
            value_eff   = value_reg;
            halted_eff  = halted_reg;
        end
    end

    // varint accumulate and length countdowns
    always_comb begin
        cnt_clamp = (cnt_eff > 3'd4) ? 3'd4 : cnt_eff;
        case (cnt_clamp)
            3'd0:    acc_part = {25'd0, s_tdata[6:0]};
            3'd1:    acc_part = {18'd0, s_tdata[6:0], 7'd0};
            3'd2:    acc_part = {11'd0, s_tdata[6:0], 14'd0};
            3'd3:    acc_part = {4'd0, s_tdata[6:0], 21'd0};
            default: acc_part = {s_tdata[3:0], 28'd0};
        endcase
        acc_new    = acc_eff | acc_part;
        suffix_dec = (suffix_eff != '0) ? suffix_eff - 1'b1 : suffix_eff;
        value_dec  = (value_eff != '0) ? value_eff - 1'b1 : value_eff;
        offset_inc = offset_eff + 1'b1;
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        key_len_next = key_len_reg;
        rd_idx_next  = rd_idx_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        shared_next  = shared_reg;
        suffix_next  = suffix_reg;
        value_next   = value_reg;
        halted_next  = halted_reg;
        s_tready     = 1'b0;
        out_ld       = 1'b0;
        ld_kind      = KIND_KEY;
        ld_code      = ERR_VARINT;
        ld_byte      = '0;
        ld_end       = 1'b0;
        ld_last      = 1'b1;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        cmp_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = out_free;
                if (s_accept) begin
                    phase_next   = phase_eff;
                    offset_next  = offset_eff;
                    key_len_next = key_len_eff;
                    acc_next     = acc_eff;
                    cnt_next     = cnt_eff;
                    shared_next  = shared_eff;
                    suffix_next  = suffix_eff;
                    value_next   = value_eff;
                    halted_next  = halted_eff;
                    if (!halted_eff) begin
                        if (offset_eff >= limit) begin
                            if (offset_eff != OFFSET_SAT) begin
                                offset_next = offset_inc;
                            end
                        end else begin
                            offset_next = offset_inc;
                            case (phase_eff)
                                PH_KEY_BYTES: begin
                                    if (key_len_eff < KLW'(KEY_MAX)) begin
                                        ram_we       = 1'b1;
                                        key_len_next = key_len_eff + 1'b1;
                                    end
                                    suffix_next = suffix_dec;
                                    out_ld      = 1'b1;
                                    ld_kind     = KIND_KEY;
                                    ld_byte     = s_tdata;
                                    if (suffix_dec == '0) begin
                                        if (value_eff == '0) begin
                                            ld_end     = 1'b1;
                                            phase_next = PH_SHARED;
                                        end else begin
                                            phase_next = PH_VAL_BYTES;
                                        end
                                    end
                                end
                                PH_VAL_BYTES: begin
                                    value_next = value_dec;
                                    out_ld     = 1'b1;
                                    ld_kind    = KIND_VALUE;
                                    ld_byte    = s_tdata;
                                    ld_end     = (value_dec == '0);
                                    if (value_dec == '0) begin
                                        phase_next = PH_SHARED;
                                    end
                                end
                                default: begin
                                    acc_next = acc_new;
                                    cnt_next = cnt_clamp + 1'b1;
                                    if (s_tdata[7]) begin
                                        if (cnt_clamp == 3'd4) begin
                                            out_ld      = 1'b1;
                                            ld_kind     = KIND_ERROR;
                                            ld_code     = ERR_VARINT;
                                            halted_next = 1'b1;
                                        end else if (offset_inc >= limit) begin
                                            out_ld      = 1'b1;
                                            ld_kind     = KIND_ERROR;
                                            ld_code     = ERR_REGION;
                                            halted_next = 1'b1;
                                        end
                                    end else begin
                                        acc_next = '0;
                                        cnt_next = '0;
                                        if (phase_eff == PH_VALUE) begin
                                            value_next = acc_new;
                                            state_next = ST_CHK_REGION;
                                        end else begin
                                            if (phase_eff == PH_SUFFIX) begin
                                                suffix_next = acc_new;
                                                phase_next  = PH_VALUE;
                                            end else begin
                                                shared_next = acc_new;
                                                phase_next  = PH_SUFFIX;
                                            end
                                            if (offset_inc >= limit) begin
                                                out_ld      = 1'b1;
                                                ld_kind     = KIND_ERROR;
                                                ld_code     = ERR_REGION;
                                                halted_next = 1'b1;
                                            end
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            ST_CHK_REGION: begin
                cmp_req.a = suffix_reg;
                cmp_req.b = value_reg;
                cmp_req.c = LEN_W'(limit - offset_reg);
                if (!cmp_gt) begin
                    state_next = ST_CHK_SHARED;
                end else if (out_free) begin
                    out_ld      = 1'b1;
                    ld_kind     = KIND_ERROR;
                    ld_code     = ERR_REGION;
                    halted_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_CHK_SHARED: begin
                cmp_req.a = shared_reg;
                cmp_req.c = LEN_W'(key_len_reg);
                if (!cmp_gt) begin
                    state_next = ST_CHK_KEY;
                end else if (out_free) begin
                    out_ld      = 1'b1;
                    ld_kind     = KIND_ERROR;
                    ld_code     = ERR_SHARED;
                    halted_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_CHK_KEY: begin
                cmp_req.a = shared_reg;
                cmp_req.b = suffix_reg;
                cmp_req.c = LEN_W'(KEY_MAX);
                if (cmp_gt) begin
                    if (out_free) begin
                        out_ld      = 1'b1;
                        ld_kind     = KIND_ERROR;
                        ld_code     = ERR_KEY_LEN;
                        halted_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else if (shared_reg != '0) begin
                    key_len_next = shared_reg[KLW-1:0];
                    rd_idx_next  = '0;
                    state_next   = ST_BURST_RD;
                    if (entry_done) begin
                        phase_next = PH_SHARED;
                    end else if (suffix_reg != '0) begin
                        phase_next = PH_KEY_BYTES;
                    end else begin
                        phase_next = PH_VAL_BYTES;
                    end
                end else if (!entry_done) begin
                    key_len_next = '0;
                    state_next   = ST_IDLE;
                    phase_next   = (suffix_reg != '0) ? PH_KEY_BYTES : PH_VAL_BYTES;
                end else if (out_free) begin
                    key_len_next = '0;
                    out_ld       = 1'b1;
                    ld_kind      = KIND_EMPTY;
                    ld_end       = 1'b1;
                    phase_next   = PH_SHARED;
                    state_next   = ST_IDLE;
                end
            end
            ST_BURST_RD: begin
                ram_re     = 1'b1;
                state_next = ST_BURST_OUT;
            end
            ST_BURST_OUT: begin
                if (out_free) begin
                    out_ld  = 1'b1;
                    ld_kind = KIND_KEY;
                    ld_byte = ram_rdata;
                    ld_last = (rd_idx_reg + 1'b1) == shared_reg[KLW-1:0];
                    ld_end  = ld_last && entry_done;
                    if (ld_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_BURST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_SHARED;
            region_reg  <= '0;
            offset_reg  <= '0;
            key_len_reg <= '0;
            rd_idx_reg  <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            shared_reg  <= '0;
            suffix_reg  <= '0;
            value_reg   <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            region_reg  <= region_next;
            offset_reg  <= offset_next;
            key_len_reg <= key_len_next;
            rd_idx_reg  <= rd_idx_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            shared_reg  <= shared_next;
            suffix_reg  <= suffix_next;
            value_reg   <= value_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            m_kind_reg <= ld_kind;
            m_code_reg <= (ld_kind == KIND_ERROR) ? ld_code : ERR_VARINT;
            m_byte_reg <= ld_byte;
            m_end_reg  <= ld_end;
            m_last_reg <= ld_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_code_reg, m_end_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while an entry is still in work");

    a_key_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_len_reg <= KLW'(KEY_MAX))
        else $error("key length beyond key buffer");

    a_burst_in_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BURST_RD || state_reg == ST_BURST_OUT)
            |-> (LEN_W'(rd_idx_reg) < shared_reg))
        else $error("prefix read beyond shared length");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_kind_reg == KIND_ERROR) |-> halted_reg)
        else $error("error word without halt");
`endif

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the prefix key block entry decoder
`timescale 1ns / 1ps

module testbench;
    import pkbd_pkg::*;

    localparam int unsigned KEY_MAX       = 64;
    localparam int unsigned BLOCK_MAX     = 65536;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       entry_end;
        err_t       code;
        logic       run_last;
    } dec_word_t;

    typedef struct packed {
        bit         blk_start;
        logic [7:0] dbyte;
        bit         typed;
        bit         one_word;
        kind_t      kind;
        err_t       code;
        bit         entry_end;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // block_byte
    logic [0:0]  s_tuser;     // block_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;     // data_byte
    logic [4:0]  m_tuser;     // item_kind[1:0], entry_end[2], error_code[4:3]
    logic        m_tlast;     // run_last

    prefix_key_block_entry_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // decoder state as the testbench sees it
    logic [16:0] region_len;
    logic [7:0]  key_buf [KEY_MAX];
    int unsigned key_len;
    int unsigned offset_cnt;
    int unsigned acc_count;
    logic [31:0] len_accum;
    logic [31:0] shared_len;
    logic [31:0] suffix_left;
    logic [31:0] value_left;
    phase_t      phase;
    bit          halted;

    dec_word_t   expected_words[$];
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 62;

    // shared prefix rebuild, padded varints, error halts and the region limit
    stim_row_t script [31] = '{
        '{1'b1, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b1, 1'b1, KIND_EMPTY, ERR_VARINT,  1'b1},
        '{1'b0, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h02, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h01, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h7F, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h82, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h80, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h80, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h80, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h10, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h03, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b1, 1'b1, KIND_ERROR, ERR_SHARED,  1'b0},
        '{1'b0, 8'h55, 1'b1, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b1, 8'h80, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'hFF, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'hFF, 1'b1, 1'b1, KIND_ERROR, ERR_VARINT,  1'b0},
        '{1'b1, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h41, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b1, 1'b1, KIND_ERROR, ERR_KEY_LEN, 1'b0},
        '{1'b1, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h00, 1'b0, 1'b0, KIND_KEY,   ERR_VARINT,  1'b0},
        '{1'b0, 8'h7F, 1'b1, 1'b1, KIND_ERROR, ERR_REGION,  1'b0}
    };

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic dec_word_t make_word(kind_t k, logic [7:0] d, logic e, err_t c);
        dec_word_t w;
        w.kind      = k;
        w.data      = d;
        w.entry_end = e;
        w.code      = c;
        w.run_last  = 1'b0;
        return w;
    endfunction

    function automatic void clear_decoder();
        key_len     = 0;
        offset_cnt  = 0;
        phase       = PH_SHARED;
        len_accum   = '0;
        acc_count   = 0;
        shared_len  = '0;
        suffix_left = '0;
        value_left  = '0;
        halted      = 1'b0;
    endfunction

    // expected words for one accepted byte
    function automatic void predict_byte(bit blk_start, logic [7:0] b, ref dec_word_t res[$]);
        int unsigned lim;
        int unsigned i;
        logic [31:0] grp;
        logic [31:0] v;
        dec_word_t   w;
        res.delete();
        if (blk_start) clear_decoder();
        if (halted) return;
        lim = (region_len > BLOCK_MAX) ? BLOCK_MAX : region_len;
        if (offset_cnt >= lim) begin
            if (offset_cnt < OFFSET_SAT) offset_cnt++;
            return;
        end
        offset_cnt++;
        if (phase == PH_KEY_BYTES) begin
            if (key_len < KEY_MAX) begin
                key_buf[key_len] = b;
                key_len++;
            end
            if (suffix_left != 0) suffix_left--;
            res.push_back(make_word(KIND_KEY, b, suffix_left == 0 && value_left == 0,
                                    ERR_VARINT));
            if (suffix_left == 0) begin
                if (value_left == 0) phase = PH_SHARED;
                else phase = PH_VAL_BYTES;
            end
        end else if (phase == PH_VAL_BYTES) begin
            if (value_left != 0) value_left--;
            res.push_back(make_word(KIND_VALUE, b, value_left == 0, ERR_VARINT));
            if (value_left == 0) phase = PH_SHARED;
        end else begin
            if (acc_count > 4) acc_count = 4;
            grp = {25'd0, b[6:0]};
            len_accum = len_accum | (grp << (7 * acc_count));
            acc_count++;
            if (b[7]) begin
                if (acc_count >= 5)
                    res.push_back(make_word(KIND_ERROR, 8'd0, 1'b0, ERR_VARINT));
                else if (offset_cnt >= lim)
                    res.push_back(make_word(KIND_ERROR, 8'd0, 1'b0, ERR_REGION));
            end else begin
                v = len_accum;
                len_accum = '0;
                acc_count = 0;
                if (phase == PH_SHARED || phase == PH_SUFFIX) begin
                    if (phase == PH_SHARED) begin
                        shared_len = v;
                        phase = PH_SUFFIX;
                    end else begin
                        suffix_left = v;
                        phase = PH_VALUE;
                    end
                    if (offset_cnt >= lim)
                        res.push_back(make_word(KIND_ERROR, 8'd0, 1'b0, ERR_REGION));
                end else begin
                    value_left = v;
                    if (64'(suffix_left) + 64'(value_left) > 64'(lim - offset_cnt))
                        res.push_back(make_word(KIND_ERROR, 8'd0, 1'b0, ERR_REGION));
                    else if (shared_len > key_len)
                        res.push_back(make_word(KIND_ERROR, 8'd0, 1'b0, ERR_SHARED));
                    else if (64'(shared_len) + 64'(suffix_left) > KEY_MAX)
                        res.push_back(make_word(KIND_ERROR, 8'd0, 1'b0, ERR_KEY_LEN));
                    else begin
                        // shared prefix comes out of the key buffer in one burst
                        for (i = 0; i < shared_len; i++)
                            res.push_back(make_word(KIND_KEY, key_buf[i],
                                i == shared_len - 1 && suffix_left == 0 && value_left == 0,
                                ERR_VARINT));
                        key_len = shared_len;
                        if (suffix_left == 0 && value_left == 0) begin
                            if (shared_len == 0)
                                res.push_back(make_word(KIND_EMPTY, 8'd0, 1'b1, ERR_VARINT));
                            phase = PH_SHARED;
                        end else if (suffix_left != 0) begin
                            phase = PH_KEY_BYTES;
                        end else begin
                            phase = PH_VAL_BYTES;
                        end
                    end
                end
            end
        end
        if (res.size() > 0) begin
            w = res.pop_back();
            if (w.kind == KIND_ERROR) halted = 1'b1;
            w.run_last = 1'b1;
            res.push_back(w);
        end
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40)
            $display("cycle %0d: %s got %0h, expected %0h", cycle_count, field, got, want);
        mismatches++;
    endtask

    task automatic check_word();
        dec_word_t want;
        if (expected_words.size() == 0) begin
            flag_mismatch("word with nothing pending", 32'({m_tuser, m_tdata}), '0);
            return;
        end
        want = expected_words.pop_front();
        if (m_tuser[1:0] !== want.kind)
            flag_mismatch("item_kind", 32'(m_tuser[1:0]), 32'(want.kind));
        if (m_tdata !== want.data)
            flag_mismatch("data_byte", 32'(m_tdata), 32'(want.data));
        if (m_tuser[2] !== want.entry_end)
            flag_mismatch("entry_end", 32'(m_tuser[2]), 32'(want.entry_end));
        if (m_tuser[4:3] !== want.code)
            flag_mismatch("error_code", 32'(m_tuser[4:3]), 32'(want.code));
        if (m_tlast !== want.run_last)
            flag_mismatch("run_last", 32'(m_tlast), 32'(want.run_last));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_word();
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic feed_byte(bit blk_start, logic [7:0] b, bit keep);
        dec_word_t words[$];
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= blk_start;
        do @(posedge aclk); while (!s_tready);
        predict_byte(blk_start, b, words);
        if (keep) foreach (words[k]) expected_words.push_back(words[k]);
    endtask

    task automatic write_region(logic [16:0] v);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        region_len = v;
    endtask

    // minimal, zero-padded or overlong length encodings
    function automatic void add_varint(int unsigned v, ref logic [8:0] blk[$]);
        int unsigned groups;
        int unsigned r;
        int unsigned i;
        logic [7:0]  bv;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            repeat (5) blk.push_back({1'b0, 1'b1, 7'($urandom)});
            return;
        end
        groups = 1;
        while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
        if (r < 12) groups = $urandom_range(groups, 5);
        for (i = 0; i < groups; i++) begin
            bv = {1'b0, 7'(v >> (7 * i))};
            if (i < groups - 1) bv[7] = 1'b1;
            else if (i == 4) bv[6:4] = 3'($urandom);
            blk.push_back({1'b0, bv});
        end
    endfunction

    function automatic void build_block(ref logic [8:0] blk[$]);
        int unsigned klen;
        int unsigned n_ent;
        int unsigned e;
        int unsigned shared;
        int unsigned room;
        int unsigned suffix;
        int unsigned value;
        int unsigned r;
        int unsigned cut;
        logic [8:0]  w;
        blk.delete();
        klen = 0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) blk.push_back({1'b0, 8'($urandom)});
        end else begin
            n_ent = $urandom_range(1, 5);
            for (e = 0; e < n_ent; e++) begin
                r = $urandom_range(0, 99);
                if (r < 6) shared = klen + 1;
                else shared = $urandom_range(0, klen);
                room = (shared < KEY_MAX) ? KEY_MAX - shared : 0;
                r = $urandom_range(0, 99);
                if (r < 10) suffix = $urandom_range(0, room);
                else if (r < 14) suffix = room + 1 + $urandom_range(0, 2);
                else suffix = $urandom_range(0, (room < 5) ? room : 5);
                value = ($urandom_range(0, 99) < 4) ? 70000 : $urandom_range(0, 4);
                add_varint(shared, blk);
                add_varint(suffix, blk);
                add_varint(value, blk);
                if (shared > klen || shared + suffix > KEY_MAX || value > 4) break;
                repeat (suffix) blk.push_back({1'b0, 8'($urandom)});
                repeat (value) blk.push_back({1'b0, 8'($urandom)});
                klen = shared + suffix;
            end
            // cut the block short so the next start lands mid entry
            if ($urandom_range(0, 6) == 0) begin
                cut = $urandom_range(1, blk.size());
                while (blk.size() > cut) void'(blk.pop_back());
            end
        end
        w = blk.pop_front();
        blk.push_front({1'b1, w[7:0]});
    endfunction

    task automatic run_random(int unsigned n_target);
        logic [8:0]  blk[$];
        int unsigned sent;
        sent = 0;
        while (sent < n_target) begin
            build_block(blk);
            foreach (blk[k]) begin
                if (sent < n_target) begin
                    feed_byte(blk[k][8], blk[k][7:0], 1'b1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        dec_word_t fixed_word;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        region_len = '0;
        clear_decoder();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty region: everything ignored
        write_region(17'd0);
        repeat (4) feed_byte(1'($urandom), 8'($urandom), 1'b1);

        write_region(17'd100);
        foreach (script[i]) begin
            feed_byte(script[i].blk_start, script[i].dbyte, !script[i].typed);
            if (script[i].typed && script[i].one_word) begin
                fixed_word = make_word(script[i].kind, 8'd0, script[i].entry_end, script[i].code);
                fixed_word.run_last = 1'b1;
                expected_words.push_back(fixed_word);
            end
        end

        write_region(17'd65536);
        run_random(55);
        write_region(17'd25);
        run_random(55);

        send_idle_pct = 62;
        recv_idle_pct = 15;
        write_region(17'd131071);
        run_random(55);
        write_region(17'd9);
        run_random(55);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_region(17'd1000);
        run_random(55);
        write_region(17'd65535);
        run_random(55);

        // one empty entry, then bytes past the region end
        write_region(17'd3);
        feed_byte(1'b1, 8'h00, 1'b1);
        feed_byte(1'b0, 8'h00, 1'b1);
        feed_byte(1'b0, 8'h00, 1'b1);
        repeat (3) feed_byte(1'b0, 8'($urandom), 1'b1);

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
